### rtl/fcull_pkg.sv
`default_nettype none

package fcull_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int NUM_PLANE_REGS = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int PLANE_W = 64;

  localparam int COORD_W = 28;
  localparam int NORM_W = 12;
  localparam int DIST_OUT_W = 27;

  // Operand width after adding or subtracting two coordinates.
  localparam int OPND_W = COORD_W + 1;
  // Normal times operand, and absolute normal times operand.
  localparam int DPROD_W = NORM_W + OPND_W;
  localparam int EPROD_W = NORM_W + 1 + OPND_W;
  // Wide enough for three products plus the doubled plane offset, and for its negation.
  localparam int SUM_W = 45;

  localparam logic [DIST_OUT_W-1:0] DIST_MAX = {DIST_OUT_W{1'b1}};

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;
  localparam logic [1:0] KIND_DIST   = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE    = 2'd0,
    VERDICT_INSIDE     = 2'd1,
    VERDICT_INTERSECTS = 2'd2
  } verdict_t;

  function automatic logic signed [NORM_W-1:0] plane_nx(input logic [PLANE_W-1:0] r);
    plane_nx = $signed(r[11:0]);
  endfunction

  function automatic logic signed [NORM_W-1:0] plane_ny(input logic [PLANE_W-1:0] r);
    plane_ny = $signed(r[23:12]);
  endfunction

  function automatic logic signed [NORM_W-1:0] plane_nz(input logic [PLANE_W-1:0] r);
    plane_nz = $signed(r[35:24]);
  endfunction

  function automatic logic signed [COORD_W-1:0] plane_d(input logic [PLANE_W-1:0] r);
    plane_d = $signed(r[63:36]);
  endfunction

endpackage

`default_nettype wire

### rtl/frustum_cull_test.sv
`default_nettype none

// Frustum culling test against six configured planes. The block takes one item
// in every cycle unless the result side stalls it, and each item passes through
// an input register, a product register fed by six plane units of three
// normal-times-coordinate multipliers and three absolute-normal-times-extent
// multipliers each, and a result register after the per-plane sums, compares and
// distance maximum.
// Backpressure on the result side stalls the pipeline; empty stages still fill.
// Plane registers are written through the configuration channel, which is
// always ready; writes must happen only while no item is in flight.
module frustum_cull_test (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [fcull_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [fcull_pkg::PLANE_W-1:0]          cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [1:0]                             kind,
  input  wire logic                                   fast,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]   pos_x,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]   pos_y,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]   pos_z,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]   aux_x,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]   aux_y,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]   aux_z,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [1:0]                                  verdict,
  output logic [fcull_pkg::DIST_OUT_W-1:0]            outside_distance
);

  localparam int NP = fcull_pkg::PLANE_COUNT;

  logic [fcull_pkg::PLANE_W-1:0] plane [fcull_pkg::NUM_PLANE_REGS];

  // Stage 1: input register.
  logic                                 v1;
  logic [1:0]                           kind1;
  logic                                 fast1;
  logic signed [fcull_pkg::COORD_W-1:0] p1 [3];
  logic signed [fcull_pkg::COORD_W-1:0] a1 [3];

  // Stage 2: product register.
  logic                                 v2;
  logic [1:0]                           kind2;
  logic                                 fast2;
  logic signed [fcull_pkg::COORD_W-1:0] rad2;
  logic signed [fcull_pkg::DPROD_W-1:0] dprod [NP][3];
  logic signed [fcull_pkg::EPROD_W-1:0] eprod [NP][3];
  logic signed [fcull_pkg::DPROD_W-1:0] dprod_next [NP][3];
  logic signed [fcull_pkg::EPROD_W-1:0] eprod_next [NP][3];

  logic adv_o, adv2, adv1;

  fcull_pkg::verdict_t                verdict_next;
  logic [fcull_pkg::DIST_OUT_W-1:0]   distance_next;

  assign adv_o     = !out_valid || out_ready;
  assign adv2      = !v2 || adv_o;
  assign adv1      = !v1 || adv2;
  assign in_ready  = adv1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcull_pkg::NUM_PLANE_REGS; i++) begin
        plane[i] <= '0;
      end
    end else if (cfg_valid && (32'(cfg_index) < fcull_pkg::NUM_PLANE_REGS)) begin
      plane[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      kind1 <= kind;
      fast1 <= fast;
      p1[0] <= pos_x;
      p1[1] <= pos_y;
      p1[2] <= pos_z;
      a1[0] <= aux_x;
      a1[1] <= aux_y;
      a1[2] <= aux_z;
    end
  end

  // Box items multiply by min+max and max-min; other kinds by the position.
  always_comb begin
    logic signed [fcull_pkg::OPND_W-1:0] opa;
    logic signed [fcull_pkg::OPND_W-1:0] opb;
    logic signed [fcull_pkg::NORM_W-1:0] n;
    logic signed [fcull_pkg::NORM_W:0]   nabs;
    for (int j = 0; j < NP; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (kind1 == fcull_pkg::KIND_BOX) begin
          opa = fcull_pkg::OPND_W'(p1[k]) + fcull_pkg::OPND_W'(a1[k]);
        end else begin
          opa = fcull_pkg::OPND_W'(p1[k]);
        end
        opb = fcull_pkg::OPND_W'(a1[k]) - fcull_pkg::OPND_W'(p1[k]);
        case (k)
          0:       n = fcull_pkg::plane_nx(plane[j]);
          1:       n = fcull_pkg::plane_ny(plane[j]);
          default: n = fcull_pkg::plane_nz(plane[j]);
        endcase
        nabs = n[fcull_pkg::NORM_W-1] ? -(fcull_pkg::NORM_W+1)'(n)
                                      : (fcull_pkg::NORM_W+1)'(n);
        dprod_next[j][k] = fcull_pkg::DPROD_W'(n) * fcull_pkg::DPROD_W'(opa);
        eprod_next[j][k] = fcull_pkg::EPROD_W'(nabs) * fcull_pkg::EPROD_W'(opb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      kind2 <= kind1;
      fast2 <= fast1;
      rad2  <= a1[0];
      dprod <= dprod_next;
      eprod <= eprod_next;
    end
  end

  always_comb begin
    logic signed [fcull_pkg::SUM_W-1:0] pdist;
    logic signed [fcull_pkg::SUM_W-1:0] ext;
    logic signed [fcull_pkg::SUM_W-1:0] thr;
    logic signed [fcull_pkg::SUM_W-1:0] dterm;
    logic signed [fcull_pkg::SUM_W-1:0] worst;
    logic [fcull_pkg::SUM_W-11:0]       q;
    logic                               outside;
    logic                               partial;
    outside = 1'b0;
    partial = 1'b0;
    worst   = '0;
    for (int j = 0; j < NP; j++) begin
      dterm = fcull_pkg::SUM_W'(fcull_pkg::plane_d(plane[j]));
      if (kind2 == fcull_pkg::KIND_BOX) begin
        dterm = dterm <<< 11;
      end else begin
        dterm = dterm <<< 10;
      end
      pdist = fcull_pkg::SUM_W'(dprod[j][0]) + fcull_pkg::SUM_W'(dprod[j][1])
            + fcull_pkg::SUM_W'(dprod[j][2]) + dterm;
      ext   = fcull_pkg::SUM_W'(eprod[j][0]) + fcull_pkg::SUM_W'(eprod[j][1])
            + fcull_pkg::SUM_W'(eprod[j][2]);
      case (kind2)
        fcull_pkg::KIND_BOX:    thr = ext;
        fcull_pkg::KIND_SPHERE: thr = fcull_pkg::SUM_W'(rad2) <<< 10;
        default:                thr = '0;
      endcase
      if (pdist < -thr) begin
        outside = 1'b1;
      end else if (pdist < thr) begin
        partial = 1'b1;
      end
      if (-pdist > worst) begin
        worst = -pdist;
      end
    end
    // Worst is never negative here, so the shift truncates toward zero.
    q = worst[fcull_pkg::SUM_W-1:10];
    distance_next = '0;
    verdict_next  = fcull_pkg::VERDICT_INSIDE;
    if (kind2 == fcull_pkg::KIND_DIST) begin
      if (q > (fcull_pkg::SUM_W-10)'(fcull_pkg::DIST_MAX)) begin
        distance_next = fcull_pkg::DIST_MAX;
      end else begin
        distance_next = q[fcull_pkg::DIST_OUT_W-1:0];
      end
    end else if (outside) begin
      verdict_next = fcull_pkg::VERDICT_OUTSIDE;
    end else if (partial && !fast2 && kind2 != fcull_pkg::KIND_POINT) begin
      verdict_next = fcull_pkg::VERDICT_INTERSECTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_o) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && v2) begin
      verdict          <= verdict_next;
      outside_distance <= distance_next;
    end
  end

endmodule

`default_nettype wire

### sim/tb_frustum_cull_test.sv
`timescale 1ns / 100ps

module tb_frustum_cull_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int U = 4096;  // one unit in Q15.12

  typedef struct {
    logic [1:0]                           kind;
    logic                                 fast;
    logic signed [fcull_pkg::COORD_W-1:0] pos_x;
    logic signed [fcull_pkg::COORD_W-1:0] pos_y;
    logic signed [fcull_pkg::COORD_W-1:0] pos_z;
    logic signed [fcull_pkg::COORD_W-1:0] aux_x;
    logic signed [fcull_pkg::COORD_W-1:0] aux_y;
    logic signed [fcull_pkg::COORD_W-1:0] aux_z;
  } cull_item_t;

  typedef struct {
    fcull_pkg::verdict_t              verdict;
    logic [fcull_pkg::DIST_OUT_W-1:0] distance;
  } cull_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fcull_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fcull_pkg::PLANE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = fcull_pkg::KIND_POINT;
  logic fast = 1'b0;
  logic signed [fcull_pkg::COORD_W-1:0] pos_x = '0;
  logic signed [fcull_pkg::COORD_W-1:0] pos_y = '0;
  logic signed [fcull_pkg::COORD_W-1:0] pos_z = '0;
  logic signed [fcull_pkg::COORD_W-1:0] aux_x = '0;
  logic signed [fcull_pkg::COORD_W-1:0] aux_y = '0;
  logic signed [fcull_pkg::COORD_W-1:0] aux_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] verdict;
  logic [fcull_pkg::DIST_OUT_W-1:0] outside_distance;

  logic [fcull_pkg::PLANE_W-1:0] plane_regs [fcull_pkg::NUM_PLANE_REGS];
  cull_result_t pending_results [$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  frustum_cull_test dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .fast             (fast),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .pos_z            (pos_z),
    .aux_x            (aux_x),
    .aux_y            (aux_y),
    .aux_z            (aux_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .verdict          (verdict),
    .outside_distance (outside_distance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < fcull_pkg::NUM_PLANE_REGS; i++) plane_regs[i] = '0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch on %s at cycle %0d: expected %0d, got %0d", what, cycle_count, want, got);
    errors++;
  endtask

  // Exact per-plane distances at 22 fraction bits, kept in 64-bit signed math.
  function automatic cull_result_t predict_cull(input cull_item_t it);
    longint nx, ny, nz, d22, pdist, ext, rad, worst, q;
    longint px, py, pz, ax, ay, az;
    bit outside, straddles;
    cull_result_t r;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    pz = longint'(it.pos_z);
    ax = longint'(it.aux_x);
    ay = longint'(it.aux_y);
    az = longint'(it.aux_z);
    outside = 1'b0;
    straddles = 1'b0;
    worst = 0;
    for (int p = 0; p < fcull_pkg::PLANE_COUNT; p++) begin
      nx = longint'($signed(plane_regs[p][11:0]));
      ny = longint'($signed(plane_regs[p][23:12]));
      nz = longint'($signed(plane_regs[p][35:24]));
      d22 = longint'($signed(plane_regs[p][63:36])) * 1024;
      if (it.kind == fcull_pkg::KIND_BOX) begin
        pdist = nx * (px + ax) + ny * (py + ay) + nz * (pz + az) + 2 * d22;
        ext = (nx < 0 ? -nx : nx) * (ax - px) + (ny < 0 ? -ny : ny) * (ay - py)
            + (nz < 0 ? -nz : nz) * (az - pz);
        if (pdist < -ext) outside = 1'b1;
        else if (pdist < ext) straddles = 1'b1;
      end else begin
        pdist = nx * px + ny * py + nz * pz + d22;
        case (it.kind)
          fcull_pkg::KIND_POINT: begin
            if (pdist < 0) outside = 1'b1;
          end
          fcull_pkg::KIND_SPHERE: begin
            rad = ax * 1024;
            if (pdist < -rad) outside = 1'b1;
            else if (pdist < rad) straddles = 1'b1;
          end
          default: begin
            if (-pdist > worst) worst = -pdist;
          end
        endcase
      end
    end
    r.distance = '0;
    if (it.kind == fcull_pkg::KIND_DIST) begin
      q = worst >>> 10;
      r.verdict = fcull_pkg::VERDICT_INSIDE;
      r.distance = (q > longint'(fcull_pkg::DIST_MAX)) ? fcull_pkg::DIST_MAX
                                                        : q[fcull_pkg::DIST_OUT_W-1:0];
    end else if (outside) begin
      r.verdict = fcull_pkg::VERDICT_OUTSIDE;
    end else if (straddles && !it.fast) begin
      r.verdict = fcull_pkg::VERDICT_INTERSECTS;
    end else begin
      r.verdict = fcull_pkg::VERDICT_INSIDE;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    cull_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, verdict);
      end else begin
        want = pending_results.pop_front();
        if (verdict !== want.verdict)
          report_mismatch("verdict", want.verdict, verdict);
        if (outside_distance !== want.distance)
          report_mismatch("outside_distance", want.distance, outside_distance);
      end
    end
  end

  task automatic send_item(input cull_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    fast <= it.fast;
    pos_x <= it.pos_x;
    pos_y <= it.pos_y;
    pos_z <= it.pos_z;
    aux_x <= it.aux_x;
    aux_y <= it.aux_y;
    aux_z <= it.aux_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_cull(it));
  endtask

  task automatic write_plane(input int idx, input logic [fcull_pkg::PLANE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[fcull_pkg::CFG_INDEX_W-1:0];
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    plane_regs[idx] = value;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [fcull_pkg::PLANE_W-1:0] pack_plane(input int nx, input int ny,
                                                               input int nz, input int d);
    return {d[27:0], nz[11:0], ny[11:0], nx[11:0]};
  endfunction

  function automatic cull_item_t make_item(input logic [1:0] k, input logic f,
                                           input int px, input int py, input int pz,
                                           input int ax, input int ay, input int az);
    cull_item_t it;
    it.kind = k;
    it.fast = f;
    it.pos_x = px[fcull_pkg::COORD_W-1:0];
    it.pos_y = py[fcull_pkg::COORD_W-1:0];
    it.pos_z = pz[fcull_pkg::COORD_W-1:0];
    it.aux_x = ax[fcull_pkg::COORD_W-1:0];
    it.aux_y = ay[fcull_pkg::COORD_W-1:0];
    it.aux_z = az[fcull_pkg::COORD_W-1:0];
    return it;
  endfunction

  // Mostly coordinates near the frustum, some far out, some with every bit random.
  function automatic logic signed [fcull_pkg::COORD_W-1:0] rand_coord();
    int v;
    case ($urandom_range(9))
      0, 1: v = $urandom;
      2, 3: v = int'($urandom_range(1 << 23)) - (1 << 22);
      default: v = int'($urandom_range(1 << 17)) - (1 << 16);
    endcase
    return v[fcull_pkg::COORD_W-1:0];
  endfunction

  // A roughly box-shaped frustum around the origin; now and then a plane of raw bits.
  function automatic logic [fcull_pkg::PLANE_W-1:0] random_plane(input int idx);
    int axis;
    int n [3];
    int d;
    axis = idx / 2;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    for (int a = 0; a < 3; a++) n[a] = int'($urandom_range(512)) - 256;
    n[axis] = 1024 - int'($urandom_range(200));
    if (idx % 2 == 1) n[axis] = -n[axis];
    d = int'($urandom_range(16 * U, 4 * U));
    return pack_plane(n[0], n[1], n[2], d);
  endfunction

  function automatic cull_item_t random_item();
    cull_item_t it;
    it.kind = 2'($urandom_range(3));
    it.fast = 1'($urandom_range(1));
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    it.pos_z = rand_coord();
    it.aux_x = fcull_pkg::COORD_W'($urandom);
    it.aux_y = fcull_pkg::COORD_W'($urandom);
    it.aux_z = fcull_pkg::COORD_W'($urandom);
    if (it.kind == fcull_pkg::KIND_SPHERE) begin
      if ($urandom_range(9) == 0) it.aux_x = rand_coord();
      else it.aux_x = fcull_pkg::COORD_W'($urandom_range(1 << 15));
    end else if (it.kind == fcull_pkg::KIND_BOX && $urandom_range(9) != 0) begin
      it.aux_x = fcull_pkg::COORD_W'(it.pos_x + $urandom_range(1 << 15));
      it.aux_y = fcull_pkg::COORD_W'(it.pos_y + $urandom_range(1 << 15));
      it.aux_z = fcull_pkg::COORD_W'(it.pos_z + $urandom_range(1 << 15));
    end else if (it.kind == fcull_pkg::KIND_BOX) begin
      it.aux_x = rand_coord();
      it.aux_y = rand_coord();
      it.aux_z = rand_coord();
    end
    return it;
  endfunction

  // All planes are zero out of reset, so every distance is zero.
  task automatic test_reset_planes();
    send_item(make_item(fcull_pkg::KIND_POINT, 1'b0, 5 * U, -3 * U, 7, 0, 0, 0));
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, 0, 0, 0, U, 0, 0));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b0, -U, -U, -U, U, U, U));
    send_item(make_item(fcull_pkg::KIND_DIST, 1'b0, 9 * U, 9 * U, 9 * U, 0, 0, 0));
  endtask

  // Axis-aligned cube of half size eight units.
  task automatic test_cube_frustum();
    drain_results();
    for (int p = 0; p < fcull_pkg::NUM_PLANE_REGS; p++)
      write_plane(p, pack_plane(p / 2 == 0 ? (p % 2 ? -1024 : 1024) : 0,
                                p / 2 == 1 ? (p % 2 ? -1024 : 1024) : 0,
                                p / 2 == 2 ? (p % 2 ? -1024 : 1024) : 0, 8 * U));
    send_item(make_item(fcull_pkg::KIND_POINT, 1'b0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(fcull_pkg::KIND_POINT, 1'b1, 9 * U, 0, 0, 0, 0, 0));
    // A point exactly on a plane has distance zero and counts as inside.
    send_item(make_item(fcull_pkg::KIND_POINT, 1'b0, 8 * U, 0, 0, 0, 0, 0));
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, 9 * U, 0, 0, 2 * U, 0, 0));
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b1, 9 * U, 0, 0, 2 * U, 0, 0));
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, 11 * U, 0, 0, 2 * U, 0, 0));
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, 0, 0, 0, U, 0, 0));
    // A negative radius shrinks the sphere test past the plane.
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, 7 * U + U / 2, 0, 0, -U, 0, 0));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b0, -U, -U, -U, U, U, U));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b0, 7 * U, -U, -U, 9 * U, U, U));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b1, 7 * U, -U, -U, 9 * U, U, U));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b0, 9 * U, 0, 0, 10 * U, U, U));
    // Min above max gives negative extents, used as they are.
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b0, 7 * U, U, U, 9 * U, -U, -U));
    send_item(make_item(fcull_pkg::KIND_DIST, 1'b1, 0, 0, 0, 3, 4, 5));
    send_item(make_item(fcull_pkg::KIND_DIST, 1'b0, 10 * U, -11 * U, 0, 0, 0, 0));
    send_item(make_item(fcull_pkg::KIND_DIST, 1'b0, 8 * U + 1, 0, 0, 0, 0, 0));
  endtask

  task automatic test_extreme_planes();
    int cmax;
    int cmin;
    cmax = (1 << 27) - 1;
    cmin = -(1 << 27);
    drain_results();
    for (int p = 0; p < fcull_pkg::NUM_PLANE_REGS; p++)
      write_plane(p, {28'h8000000, 12'h800, 12'h800, 12'h800});
    send_item(make_item(fcull_pkg::KIND_POINT, 1'b0, cmax, cmax, cmax, cmin, cmin, cmin));
    // Distance far beyond the output range saturates.
    send_item(make_item(fcull_pkg::KIND_DIST, 1'b0, cmax, cmax, cmax, 0, 0, 0));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b0, cmin, cmin, cmin, cmax, cmax, cmax));
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, cmin, cmin, cmin, cmax, 0, 0));
    drain_results();
    for (int p = 0; p < fcull_pkg::NUM_PLANE_REGS; p++)
      write_plane(p, {28'h7ffffff, 12'h7ff, 12'h7ff, 12'h7ff});
    send_item(make_item(fcull_pkg::KIND_DIST, 1'b1, cmin, cmin, cmin, cmax, cmax, cmax));
    send_item(make_item(fcull_pkg::KIND_BOX, 1'b1, cmax, cmax, cmax, cmin, cmin, cmin));
    drain_results();
    for (int p = 0; p < fcull_pkg::NUM_PLANE_REGS; p++) write_plane(p, '1);
    send_item(make_item(fcull_pkg::KIND_SPHERE, 1'b0, cmin, cmin, cmin, cmin, cmax, cmax));
    send_item(make_item(fcull_pkg::KIND_POINT, 1'b1, 0, 0, 0, -1, -1, -1));
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      drain_results();
      for (int p = 0; p < fcull_pkg::NUM_PLANE_REGS; p++) write_plane(p, random_plane(p));
      repeat (count / 3) send_item(random_item());
    end
  endtask

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 79;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_planes();
    test_cube_frustum();
    test_extreme_planes();
    test_random_stream(33, 79, 600);
    test_random_stream(79, 33, 600);
    test_random_stream(0, 0, 600);
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
